FILE: hdl/tts_pkg.sv
// ----------------------------------------------------------------------------
// Template tag segmenter package
// Shared constants, segment kind codes and the result word type.
// ----------------------------------------------------------------------------
package tts_pkg;

  // default width of the internal byte offsets
  localparam int unsigned POS_BITS_DEF = 24;

  // width of the offsets carried on the result channel
  localparam int unsigned OUT_POS_W = 24;

  // look-behind window, most recent byte first
  localparam int unsigned WIN_LEN = 9;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // tag characters
  localparam logic [7:0] CH_LT    = 8'h3C; // '<'
  localparam logic [7:0] CH_QM    = 8'h3F; // '?'
  localparam logic [7:0] CH_GT    = 8'h3E; // '>'
  localparam logic [7:0] CH_EQ    = 8'h3D; // '='
  localparam logic [7:0] CH_TWO   = 8'h32; // '2'
  localparam logic [7:0] CH_THREE = 8'h33; // '3'
  localparam logic [7:0] CH_P     = 8'h70; // 'p'
  localparam logic [7:0] CH_Y     = 8'h79; // 'y'
  localparam logic [7:0] CH_T     = 8'h74; // 't'
  localparam logic [7:0] CH_H     = 8'h68; // 'h'
  localparam logic [7:0] CH_O     = 8'h6F; // 'o'
  localparam logic [7:0] CH_N     = 8'h6E; // 'n'
  localparam logic [7:0] CH_NL    = 8'h0A; // newline
  localparam logic [7:0] CH_TAB   = 8'h09; // tab
  localparam logic [7:0] CH_SP    = 8'h20; // space

  // tag lengths: body offset from the '<'
  localparam int unsigned INLINE_TAG_LEN = 4;
  localparam int unsigned BLOCK_TAG_LEN  = 9;

  // segment kinds
  localparam logic [2:0] KIND_RAW       = 3'd0;
  localparam logic [2:0] KIND_INLINE_V2 = 3'd1;
  localparam logic [2:0] KIND_INLINE_V3 = 3'd2;
  localparam logic [2:0] KIND_BLOCK_V2  = 3'd3;
  localparam logic [2:0] KIND_BLOCK_V3  = 3'd4;

  // one result word
  typedef struct packed {
    logic [2:0]           kind;
    logic [OUT_POS_W-1:0] start;
    logic [OUT_POS_W-1:0] stop;
    logic                 last;
    logic                 ovf;
  } seg_t;

endpackage

FILE: hdl/template_tag_segmenter.sv
// ----------------------------------------------------------------------------
// Template tag segmenter
// Splits a template byte stream into raw-text and embedded-code segments.
// ----------------------------------------------------------------------------
//
//  channel | direction | words                  | handshake
//  --------+-----------+------------------------+---------------------
//  in_     | input     | one document byte      | in_valid / in_ready
//  out_    | output    | one segment descriptor | out_valid / out_ready
//
//  One byte is taken per cycle while in_ready is high; its segments (at most
//  two) enter a 4-word result queue in the same cycle and leave it one word
//  per cycle while out_ready is high. in_ready is high while the queue has
//  room for two words. Reset (rst_n low, synchronous) empties the queue and
//  clears all matcher state; an end-of-document byte returns the matcher to
//  its reset state. Stalls on out_ready only back-pressure the input once
//  fewer than two queue words are free.
//
module template_tag_segmenter #(
  parameter int unsigned POS_BITS = tts_pkg::POS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // byte input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_doc_byte,
  input  logic                           in_end_of_document,
  // segment output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_segment_kind,
  output logic [tts_pkg::OUT_POS_W-1:0]  out_segment_start,
  output logic [tts_pkg::OUT_POS_W-1:0]  out_segment_end,
  output logic                           out_last_of_run,
  output logic                           out_position_overflow
);

  localparam int unsigned OW = tts_pkg::OUT_POS_W;
  localparam int unsigned QW = tts_pkg::QPTR_W;
  localparam int unsigned CW = tts_pkg::QCNT_W;

  // low OUT_POS_W bits of an offset, zero-extended when offsets are narrower
  function automatic logic [OW-1:0] to_out(input logic [POS_BITS-1:0] v);
    logic [POS_BITS+OW-1:0] ext;
    ext = {{OW{1'b0}}, v};
    return ext[OW-1:0];
  endfunction

  // matcher state
  logic [7:0]          win_r [tts_pkg::WIN_LEN];
  logic [POS_BITS-1:0] ofs_r, origin_r, blk_at_r, inl_at_r;
  logic                blk_seen_r, blk_v3_r, inl_seen_r, inl_v3_r, ovf_r;

  logic [POS_BITS-1:0] ofs_nxt, origin_nxt, blk_at_nxt, inl_at_nxt;
  logic                blk_seen_nxt, blk_v3_nxt, inl_seen_nxt, inl_v3_nxt, ovf_nxt;

  // result queue
  tts_pkg::seg_t       q_r [tts_pkg::QUEUE_DEPTH];
  logic [QW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]       cnt_r;

  logic                in_fire, out_fire;
  logic                is_ver, inl_hit, blk_hit, is_ws, close, use_inl, raw_pre;
  logic [POS_BITS-1:0] tag, body;
  logic [2:0]          code_kind;
  tts_pkg::seg_t       w0, w1;
  logic [1:0]          push_n;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = cnt_r <= CW'(tts_pkg::QUEUE_DEPTH - 2);
  assign out_valid = cnt_r != '0;

  // tag recognition on the window plus the current byte
  always_comb begin
    is_ver  = (win_r[0] == tts_pkg::CH_TWO) || (win_r[0] == tts_pkg::CH_THREE);
    is_ws   = (in_doc_byte == tts_pkg::CH_SP) || (in_doc_byte == tts_pkg::CH_TAB) ||
              (in_doc_byte == tts_pkg::CH_NL);
    inl_hit = (in_doc_byte == tts_pkg::CH_EQ) && is_ver &&
              (win_r[1] == tts_pkg::CH_QM) && (win_r[2] == tts_pkg::CH_LT);
    blk_hit = is_ws && is_ver &&
              (win_r[1] == tts_pkg::CH_N) && (win_r[2] == tts_pkg::CH_O) &&
              (win_r[3] == tts_pkg::CH_H) && (win_r[4] == tts_pkg::CH_T) &&
              (win_r[5] == tts_pkg::CH_Y) && (win_r[6] == tts_pkg::CH_P) &&
              (win_r[7] == tts_pkg::CH_QM) && (win_r[8] == tts_pkg::CH_LT);
    // a '>' is never a tag byte or a newline, so the close sees registered state
    close   = (in_doc_byte == tts_pkg::CH_GT) && (win_r[0] == tts_pkg::CH_QM) &&
              (inl_seen_r || blk_seen_r);
    ofs_nxt = ofs_r + POS_BITS'(1);
  end

  // choose the winning tag: nearest after the segment origin
  always_comb begin
    if (inl_seen_r && blk_seen_r) begin
      use_inl = (inl_at_r - origin_r) < (blk_at_r - origin_r);
    end else begin
      use_inl = inl_seen_r;
    end
    if (use_inl) begin
      tag       = inl_at_r;
      body      = inl_at_r + POS_BITS'(tts_pkg::INLINE_TAG_LEN);
      code_kind = inl_v3_r ? tts_pkg::KIND_INLINE_V3 : tts_pkg::KIND_INLINE_V2;
    end else begin
      tag       = blk_at_r;
      body      = blk_at_r + POS_BITS'(tts_pkg::BLOCK_TAG_LEN);
      code_kind = blk_v3_r ? tts_pkg::KIND_BLOCK_V3 : tts_pkg::KIND_BLOCK_V2;
    end
    raw_pre = close && (tag != origin_r);
  end

  // next matcher state
  always_comb begin
    ovf_nxt      = ovf_r || (ofs_nxt == '0);
    origin_nxt   = origin_r;
    blk_seen_nxt = blk_seen_r;
    blk_at_nxt   = blk_at_r;
    blk_v3_nxt   = blk_v3_r;
    inl_seen_nxt = inl_seen_r && (in_doc_byte != tts_pkg::CH_NL);
    inl_at_nxt   = inl_at_r;
    inl_v3_nxt   = inl_v3_r;
    if (inl_hit && !inl_seen_r) begin
      inl_seen_nxt = 1'b1;
      inl_at_nxt   = ofs_r - POS_BITS'(3);
      inl_v3_nxt   = win_r[0] == tts_pkg::CH_THREE;
    end
    if (blk_hit && !blk_seen_r) begin
      blk_seen_nxt = 1'b1;
      blk_at_nxt   = ofs_r - POS_BITS'(tts_pkg::BLOCK_TAG_LEN);
      blk_v3_nxt   = win_r[0] == tts_pkg::CH_THREE;
    end
    if (close) begin
      origin_nxt   = ofs_nxt;
      inl_seen_nxt = 1'b0;
      blk_seen_nxt = 1'b0;
    end
  end

  // result words for this byte
  always_comb begin
    w0.kind  = tts_pkg::KIND_RAW;
    w0.start = to_out(origin_r);
    w0.stop  = to_out(ofs_nxt);
    w0.last  = 1'b1;
    w0.ovf   = ovf_nxt;
    w1.kind  = code_kind;
    w1.start = to_out(body);
    w1.stop  = to_out(ofs_r - POS_BITS'(1));
    w1.last  = 1'b1;
    w1.ovf   = ovf_nxt;
    push_n   = 2'd0;
    if (close) begin
      if (raw_pre) begin
        w0.stop = to_out(tag);
        w0.last = 1'b0;
        push_n  = 2'd2;
      end else begin
        w0     = w1;
        push_n = 2'd1;
      end
    end else if (in_end_of_document) begin
      push_n = 2'd1;
    end
  end

  // matcher registers
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_end_of_document)) begin
      for (int i = 0; i < tts_pkg::WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
      ofs_r      <= '0;
      origin_r   <= '0;
      blk_seen_r <= 1'b0;
      blk_at_r   <= '0;
      blk_v3_r   <= 1'b0;
      inl_seen_r <= 1'b0;
      inl_at_r   <= '0;
      inl_v3_r   <= 1'b0;
      ovf_r      <= 1'b0;
    end else if (in_fire) begin
      win_r[0] <= in_doc_byte;
      for (int i = 1; i < tts_pkg::WIN_LEN; i++) begin
        win_r[i] <= win_r[i-1];
      end
      ofs_r      <= ofs_nxt;
      origin_r   <= origin_nxt;
      blk_seen_r <= blk_seen_nxt;
      blk_at_r   <= blk_at_nxt;
      blk_v3_r   <= blk_v3_nxt;
      inl_seen_r <= inl_seen_nxt;
      inl_at_r   <= inl_at_nxt;
      inl_v3_r   <= inl_v3_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + QW'(push_n);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + QW'(1);
      end
      cnt_r <= cnt_r + CW'(in_fire ? push_n : 2'd0) - CW'(out_fire);
    end
  end

  // queue storage, no reset
  always_ff @(posedge clk) begin
    if (in_fire && (push_n != 2'd0)) begin
      q_r[wr_ptr_r] <= w0;
    end
    if (in_fire && (push_n == 2'd2)) begin
      q_r[wr_ptr_r + QW'(1)] <= w1;
    end
  end

  // head word onto the ports
  assign out_segment_kind      = q_r[rd_ptr_r].kind;
  assign out_segment_start     = q_r[rd_ptr_r].start;
  assign out_segment_end       = q_r[rd_ptr_r].stop;
  assign out_last_of_run       = q_r[rd_ptr_r].last;
  assign out_position_overflow = q_r[rd_ptr_r].ovf;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(tts_pkg::QUEUE_DEPTH))
    else $error("result queue count past depth");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ({1'b0, cnt_r} + (CW+1)'(push_n)) <= (CW+1)'(tts_pkg::QUEUE_DEPTH))
    else $error("segment push overruns result queue");

  a_eod_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_document) |=>
      (ofs_r == '0) && !blk_seen_r && !inl_seen_r && !ovf_r)
    else $error("matcher not returned to reset after end of document");

  a_eod_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_document) |-> (push_n != 2'd0))
    else $error("end of document produced no segment");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_segment_kind <= tts_pkg::KIND_BLOCK_V3))
    else $error("illegal segment kind at output");

endmodule

FILE: sim/template_tag_segmenter_tb.sv
// ----------------------------------------------------------------------------
// Template tag segmenter testbench
// Streams template documents into the segmenter and checks every segment word
// against a cycle-free model of the tag matcher kept alongside the stimulus.
// It uses hand-written documents for the tag forms and corner cases, then
// random documents built from tag, body, close and noise fragments, and one
// long document. Both channels stall at random.
// ----------------------------------------------------------------------------
module template_tag_segmenter_tb;

  // offsets at the block's default width
  localparam int unsigned TB_POS_BITS = tts_pkg::POS_BITS_DEF;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_doc_byte;
  logic                          in_end_of_document;
  logic                          out_valid;
  logic                          out_ready;
  logic [2:0]                    out_segment_kind;
  logic [tts_pkg::OUT_POS_W-1:0] out_segment_start;
  logic [tts_pkg::OUT_POS_W-1:0] out_segment_end;
  logic                          out_last_of_run;
  logic                          out_position_overflow;

  // matcher copy
  logic [7:0]             hist [tts_pkg::WIN_LEN];
  logic [TB_POS_BITS-1:0] cur_pos, origin, blk_at, inl_at;
  bit                     blk_open, blk_v3, inl_open, inl_v3, wrapped;

  // segments still owed by the block, oldest first
  tts_pkg::seg_t pending_segs[$];
  // document under construction
  logic [7:0] doc_q[$];

  bit quiet;
  int errors, segs_checked, ovf_seen, bytes_sent, docs_sent;

  template_tag_segmenter #(.POS_BITS(TB_POS_BITS)) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_doc_byte           (in_doc_byte),
    .in_end_of_document    (in_end_of_document),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_segment_kind      (out_segment_kind),
    .out_segment_start     (out_segment_start),
    .out_segment_end       (out_segment_end),
    .out_last_of_run       (out_last_of_run),
    .out_position_overflow (out_position_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Matcher model
  // ---------------------------------------------------------------------------
  function automatic bit is_ver(input logic [7:0] c);
    return c == tts_pkg::CH_TWO || c == tts_pkg::CH_THREE;
  endfunction

  function automatic void clear_tracker();
    foreach (hist[i]) hist[i] = 8'h00;
    cur_pos  = '0;
    origin   = '0;
    blk_open = 1'b0;
    blk_at   = '0;
    blk_v3   = 1'b0;
    inl_open = 1'b0;
    inl_at   = '0;
    inl_v3   = 1'b0;
    wrapped  = 1'b0;
  endfunction

  // works out the segments that one accepted byte releases
  function automatic void track_byte(input logic [7:0] b, input bit eod);
    logic [TB_POS_BITS-1:0] here, next_pos, tag, body, close_at, d_inl, d_blk;
    logic [2:0]             kind;
    bit                     closed, pick_inline;
    tts_pkg::seg_t          made[$];
    tts_pkg::seg_t          s;
    here     = cur_pos;
    next_pos = cur_pos + 1'b1;
    closed   = 1'b0;
    if (next_pos == '0) wrapped = 1'b1;
    // a newline cancels any pending inline tag
    if (b == tts_pkg::CH_NL) inl_open = 1'b0;
    if (b == tts_pkg::CH_EQ && is_ver(hist[0]) && hist[1] == tts_pkg::CH_QM &&
        hist[2] == tts_pkg::CH_LT && !inl_open) begin
      inl_open = 1'b1;
      inl_at   = here - 3'd3;
      inl_v3   = (hist[0] == tts_pkg::CH_THREE);
    end
    if ((b == tts_pkg::CH_SP || b == tts_pkg::CH_TAB || b == tts_pkg::CH_NL) &&
        is_ver(hist[0]) &&
        hist[1] == tts_pkg::CH_N && hist[2] == tts_pkg::CH_O &&
        hist[3] == tts_pkg::CH_H && hist[4] == tts_pkg::CH_T &&
        hist[5] == tts_pkg::CH_Y && hist[6] == tts_pkg::CH_P &&
        hist[7] == tts_pkg::CH_QM && hist[8] == tts_pkg::CH_LT && !blk_open) begin
      blk_open = 1'b1;
      blk_at   = here - 4'd9;
      blk_v3   = (hist[0] == tts_pkg::CH_THREE);
    end
    // close: earliest open tag since the segment origin wins
    if (b == tts_pkg::CH_GT && hist[0] == tts_pkg::CH_QM && (inl_open || blk_open)) begin
      close_at = here - 1'b1;
      d_inl    = inl_at - origin;
      d_blk    = blk_at - origin;
      pick_inline = (inl_open && blk_open) ? (d_inl < d_blk) : inl_open;
      if (pick_inline) begin
        tag  = inl_at;
        body = inl_at + TB_POS_BITS'(tts_pkg::INLINE_TAG_LEN);
        kind = inl_v3 ? tts_pkg::KIND_INLINE_V3 : tts_pkg::KIND_INLINE_V2;
      end else begin
        tag  = blk_at;
        body = blk_at + TB_POS_BITS'(tts_pkg::BLOCK_TAG_LEN);
        kind = blk_v3 ? tts_pkg::KIND_BLOCK_V3 : tts_pkg::KIND_BLOCK_V2;
      end
      if (tag != origin) begin
        s = '0;
        s.kind  = tts_pkg::KIND_RAW;
        s.start = origin;
        s.stop  = tag;
        made.push_back(s);
      end
      s = '0;
      s.kind  = kind;
      s.start = body;
      s.stop  = close_at;
      made.push_back(s);
      origin   = next_pos;
      inl_open = 1'b0;
      blk_open = 1'b0;
      closed   = 1'b1;
    end
    for (int k = tts_pkg::WIN_LEN - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = b;
    cur_pos = next_pos;
    // trailing raw text goes out with the final byte
    if (eod && !closed) begin
      s = '0;
      s.kind  = tts_pkg::KIND_RAW;
      s.start = origin;
      s.stop  = next_pos;
      made.push_back(s);
    end
    foreach (made[i]) begin
      made[i].last = (i == made.size() - 1);
      made[i].ovf  = wrapped;
      pending_segs.push_back(made[i]);
    end
    if (eod) clear_tracker();
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic void check_segment();
    tts_pkg::seg_t want;
    if (pending_segs.size() == 0) begin
      note_error($sformatf("unexpected word: kind %0d start %0d end %0d last %0b ovf %0b",
                           out_segment_kind, out_segment_start, out_segment_end,
                           out_last_of_run, out_position_overflow));
      return;
    end
    want = pending_segs.pop_front();
    segs_checked++;
    if (out_position_overflow) ovf_seen++;
    if (out_segment_kind !== want.kind || out_segment_start !== want.start ||
        out_segment_end !== want.stop || out_last_of_run !== want.last ||
        out_position_overflow !== want.ovf)
      note_error($sformatf({"segment mismatch: exp kind %0d start %0d end %0d last %0b ",
                            "ovf %0b, got kind %0d start %0d end %0d last %0b ovf %0b"},
                           want.kind, want.start, want.stop, want.last, want.ovf,
                           out_segment_kind, out_segment_start, out_segment_end,
                           out_last_of_run, out_position_overflow));
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_segment();
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 21);
  end

  // ---------------------------------------------------------------------------
  // Sending
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit eod);
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_doc_byte        <= b;
    in_end_of_document <= eod;
    do @(posedge clk); while (!in_ready);
    track_byte(b, eod);
    bytes_sent++;
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
    doc_q.delete();
    docs_sent++;
  endtask

  // hold the sender until every owed segment has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_segs.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Document building
  // ---------------------------------------------------------------------------
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(2))
      0:       return tts_pkg::CH_SP;
      1:       return tts_pkg::CH_TAB;
      default: return tts_pkg::CH_NL;
    endcase
  endfunction

  // raw bytes, weighted towards the characters the matcher looks at
  function automatic void add_noise(input int n);
    string hot;
    hot = "<?=23pythno> \n\t";
    repeat (n) begin
      if ($urandom_range(99) < 40) doc_q.push_back(hot[$urandom_range(hot.len() - 1)]);
      else doc_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void add_open_tag();
    if ($urandom_range(1)) begin
      if ($urandom_range(1)) add_text("<?3=");
      else add_text("<?2=");
    end else begin
      if ($urandom_range(1)) add_text("<?python3");
      else add_text("<?python2");
      doc_q.push_back(pick_ws());
    end
  endfunction

  // a tag cut short and followed by a stray letter
  function automatic void add_broken_tag();
    string t;
    int    cut;
    if ($urandom_range(1)) t = "<?python3 ";
    else t = "<?2=";
    cut = $urandom_range(1, t.len() - 1);
    for (int i = 0; i < cut; i++) doc_q.push_back(t[i]);
    doc_q.push_back(8'(97 + $urandom_range(25)));
  endfunction

  function automatic void add_fragment();
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // well-formed code segment, sometimes behind raw text
        if ($urandom_range(1)) add_noise($urandom_range(1, 4));
        add_open_tag();
        add_noise($urandom_range(0, 5));
        add_text("?>");
      end
      4, 5:    add_noise($urandom_range(1, 6));
      6:       add_text("?>");
      7:       add_broken_tag();
      8:       doc_q.push_back(tts_pkg::CH_NL);
      default: add_open_tag();
    endcase
  endfunction

  function automatic void build_doc(input int target);
    while (doc_q.size() < target) add_fragment();
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // tag forms, single-byte document, extreme byte values and special cases
  task automatic test_directed_cases();
    add_text("a");                    send_doc();
    add_text("<?2=x?>");              send_doc();  // close on final byte
    add_text("ab<?3=y?>c");           send_doc();
    add_text("<?python2 b?>");        send_doc();
    add_text("<?python3\tq?>\n");     send_doc();
    add_text("<?python3\n?>");        send_doc();  // body is just the newline
    add_text("t?>u");                 send_doc();  // close with no tag
    add_text("<?2=a\nb?>");           send_doc();  // inline broken by newline
    add_text("<?python3 <?2=z?>");    send_doc();  // block earlier, wins
    add_text("<?3=<?python2 ?>");     send_doc();  // inline earlier, wins
    add_text("<?python2x?>");         send_doc();  // no whitespace after tag
    doc_q.push_back(8'hFF);
    doc_q.push_back(8'h00);
    send_doc();
    wait_drained();
  endtask

  // random documents, mostly short, with the odd pause for a full drain
  task automatic test_random_documents();
    for (int d = 0; d < 20; d++) begin
      build_doc($urandom_range(1, 30));
      send_doc();
      if (d % 8 == 7) wait_drained();
    end
  endtask

  // back-to-back bytes with the output always ready
  task automatic test_steady_stream();
    quiet = 1'b1;
    repeat (6) begin
      build_doc($urandom_range(15, 35));
      send_doc();
    end
    wait_drained();
    quiet = 1'b0;
  endtask

  // one long document, then a short one straight after
  task automatic test_long_document();
    build_doc($urandom_range(180, 220));
    send_doc();
    wait_drained();
    build_doc($urandom_range(5, 20));
    send_doc();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_doc_byte        = 8'h00;
    in_end_of_document = 1'b0;
    out_ready          = 1'b0;
    quiet              = 1'b0;
    clear_tracker();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_documents();
    test_steady_stream();
    test_long_document();
    test_random_documents();

    wait_drained();
    repeat (12) @(posedge clk);
    if (pending_segs.size() != 0)
      note_error($sformatf("%0d segments never arrived", pending_segs.size()));
    $display("Sent %0d bytes in %0d documents; %0d segment words compared, %0d of them",
             bytes_sent, docs_sent, segs_checked, ovf_seen);
    $display("flagged as overflowed; %0d errors", errors);
    if (errors == 0) begin
      $display("template_tag_segmenter_tb: done, clean");
    end else begin
      $display("template_tag_segmenter_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("template_tag_segmenter_tb: done, errors");
    $finish;
  end

endmodule
